// File: hw/rtl/dra_pkg.sv
package dra_pkg;

   // Space and free list sizing
   localparam int OFFSET_BITS = 20;
   localparam int FREE_RANGES = 64;
   localparam int IDX_W       = $clog2(FREE_RANGES);
   localparam int CNT_W       = $clog2(FREE_RANGES + 1);

   // Field widths
   localparam int OFF_W      = 20;
   localparam int LEN_W      = 21;
   localparam int FRAME_W    = 32;
   localparam int STAT_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   // Arithmetic is done at 33 bits so the space cap fits
   localparam int WIDE_W = 33;
   localparam logic [WIDE_W-1:0] SPACE = WIDE_W'(64'd1 << OFFSET_BITS);
   localparam logic [LEN_W-1:0]  USED_MAX = '1;

   localparam logic [LEN_W-1:0] TCAP_RESET  = LEN_W'(1024);
   localparam logic [LEN_W-1:0] PCAP_RESET  = LEN_W'(1048576);

   typedef enum logic [1:0] {
      OP_FRAME   = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RS_OK         = 2'd0,
      RS_NO_SPACE   = 2'd1,
      RS_LIST_FULL  = 2'd2,
      RS_IGNORED    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TCAP  = 2'd0,
      CSR_PCAP  = 2'd1,
      CSR_BOUND = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RT_DONE     = 2'd0,
      RT_SCAN     = 2'd1,
      RT_WALK_DRY = 2'd2,
      RT_WALK_WR  = 2'd3
   } route_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_WALK_DRY,
      S_WALK_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] len;
   } hole_type;

   typedef struct packed {
      logic start;
      logic exec;
      logic scan;
      logic shift;
      logic walk;
      logic walk_wr;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      route_type route;
      logic      scan_last;
      logic      scan_shift;
      logic      shift_last;
      logic      walk_last;
      logic      walk_over;
      logic      rsp_free;
   } dp_stat_type;

endpackage

// File: hw/rtl/dra_ctrl.sv
module dra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dra_pkg::dp_stat_type stat,
   output dra_pkg::dp_cmd_type  cmd
);
   import dra_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.route)
               RT_DONE:     state_in = S_FINISH;
               RT_SCAN:     state_in = S_SCAN;
               RT_WALK_DRY: state_in = S_WALK_DRY;
               RT_WALK_WR:  state_in = S_WALK_WR;
               default:     state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            if (stat.scan_last) state_in = stat.scan_shift ? S_SHIFT : S_FINISH;
         end
         S_SHIFT: begin
            if (stat.shift_last) state_in = S_FINISH;
         end
         S_WALK_DRY: begin
            if (stat.walk_last) state_in = stat.walk_over ? S_FINISH : S_WALK_WR;
         end
         S_WALK_WR: begin
            if (stat.walk_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      cmd         = '0;
      cmd.start   = (state_ff == S_IDLE) && req_valid;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.scan    = (state_ff == S_SCAN);
      cmd.shift   = (state_ff == S_SHIFT);
      cmd.walk    = (state_ff == S_WALK_DRY) || (state_ff == S_WALK_WR);
      cmd.walk_wr = (state_ff == S_WALK_WR);
      cmd.finish  = (state_ff == S_FINISH) && stat.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/dra_datapath.sv
module dra_datapath (
   input  logic                            clock,
   input  logic                            reset,
   // request word
   input  logic [1:0]                      req_opcode,
   input  logic                            req_persistent,
   input  logic [dra_pkg::LEN_W-1:0]       req_count,
   input  logic [dra_pkg::OFF_W-1:0]       req_offset,
   input  logic [dra_pkg::FRAME_W-1:0]     req_frame_index,
   // register writes
   input  logic                            csr_write,
   input  logic [dra_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dra_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // control
   input  dra_pkg::dp_cmd_type             cmd,
   output dra_pkg::dp_stat_type            stat,
   // response word
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [dra_pkg::OFF_W-1:0]       rsp_alloc_offset,
   output logic [dra_pkg::LEN_W-1:0]       rsp_alloc_count,
   output logic [dra_pkg::FRAME_W-1:0]     rsp_frame_now,
   output logic [dra_pkg::LEN_W-1:0]       rsp_transient_used,
   output logic [dra_pkg::LEN_W-1:0]       rsp_transient_peak,
   output logic [dra_pkg::STAT_W-1:0]      rsp_transient_retired,
   output logic [dra_pkg::LEN_W-1:0]       rsp_persistent_used,
   output logic [dra_pkg::LEN_W-1:0]       rsp_persistent_peak,
   output logic [dra_pkg::STAT_W-1:0]      rsp_persistent_released,
   output logic [dra_pkg::STAT_W-1:0]      rsp_failures
);
   import dra_pkg::*;

   // Configuration
   logic [LEN_W-1:0] tcap_ff, tcap_in, pcap_ff, pcap_in;
   logic             bound_ff, bound_in;

   // Latched request
   opcode_type       op_ff, op_in;
   logic             pers_ff, pers_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   // Allocator state
   logic [LEN_W-1:0]   bump_t_ff, bump_t_in, bump_p_ff, bump_p_in;
   logic [FRAME_W-1:0] cur_frame_ff, cur_frame_in;
   logic [CNT_W-1:0]   hole_cnt_ff, hole_cnt_in;
   logic [LEN_W-1:0]   tused_ff, tused_in, tpeak_ff, tpeak_in;
   logic [LEN_W-1:0]   pused_ff, pused_in, ppeak_ff, ppeak_in;
   logic [STAT_W-1:0]  tret_ff, tret_in, prel_ff, prel_in, fail_ff, fail_in;

   // List walk
   logic [CNT_W-1:0] idx_ff, idx_in, w_ff, w_in;
   logic             pend_ff, pend_in, have_last_ff, have_last_in;
   hole_type         last_ff, last_in;

   // Result of the current word
   status_type       status_ff, status_in;
   logic [OFF_W-1:0] goff_ff, goff_in;
   logic [LEN_W-1:0] gcnt_ff, gcnt_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         r_status_ff, r_status_in;
   logic [OFF_W-1:0]   r_goff_ff, r_goff_in;
   logic [LEN_W-1:0]   r_gcnt_ff, r_gcnt_in;
   logic [FRAME_W-1:0] r_frame_ff, r_frame_in;
   logic [LEN_W-1:0]   r_tused_ff, r_tused_in, r_tpeak_ff, r_tpeak_in;
   logic [LEN_W-1:0]   r_pused_ff, r_pused_in, r_ppeak_ff, r_ppeak_in;
   logic [STAT_W-1:0]  r_tret_ff, r_tret_in, r_prel_ff, r_prel_in, r_fail_ff, r_fail_in;

   // Free list memory
   hole_type         hole_ram [FREE_RANGES];
   hole_type         rdata_ff;
   logic             we;
   logic [IDX_W-1:0] waddr;
   hole_type         wdata;
   logic [IDX_W-1:0] raddr;

   // Arithmetic helpers
   logic [WIDE_W-1:0] tcap_eff, t_sum, p_sum, plimit, rel_end;
   logic              t_fail, p_fail, rel_bad, n_zero, list_full;
   logic [LEN_W:0]    grow_sum;
   logic [LEN_W-1:0]  pused_grow, ppeak_grow, pused_rel;
   logic              cnt_hit, scan_fit, scan_exact, take_ins, adj;
   hole_type          el;
   logic [CNT_W-1:0]  idx_inc, idx_dec, w_dec;

   always_comb begin
      n_zero    = (n_ff == '0);
      list_full = (hole_cnt_ff == CNT_W'(FREE_RANGES));

      // transient capacity: zero acts as one, capped at the space
      tcap_eff = (tcap_ff == '0) ? WIDE_W'(1) : WIDE_W'(tcap_ff);
      if (tcap_eff > SPACE) tcap_eff = SPACE;
      t_sum  = WIDE_W'(bump_t_ff) + WIDE_W'(n_ff);
      t_fail = (t_sum > tcap_eff);

      plimit = SPACE;
      if (bound_ff && (WIDE_W'(pcap_ff) < SPACE)) plimit = WIDE_W'(pcap_ff);
      p_sum  = WIDE_W'(bump_p_ff) + WIDE_W'(n_ff);
      p_fail = (p_sum > plimit);

      rel_end = WIDE_W'(off_ff) + WIDE_W'(n_ff);
      rel_bad = (rel_end > SPACE);

      // saturating usage
      grow_sum   = (LEN_W + 1)'(pused_ff) + (LEN_W + 1)'(n_ff);
      pused_grow = grow_sum[LEN_W] ? USED_MAX : grow_sum[LEN_W-1:0];
      ppeak_grow = (pused_grow > ppeak_ff) ? pused_grow : ppeak_ff;
      pused_rel  = (pused_ff >= n_ff) ? (pused_ff - n_ff) : '0;

      idx_inc = idx_ff + 1'b1;
      idx_dec = idx_ff - 1'b1;
      w_dec   = w_ff - 1'b1;

      cnt_hit    = (idx_ff == hole_cnt_ff);
      scan_fit   = (rdata_ff.len >= n_ff);
      scan_exact = (rdata_ff.len == n_ff);

      // merge walk: the released range goes before the first larger start
      take_ins = pend_ff && (cnt_hit || (rdata_ff.start > off_ff));
      el       = take_ins ? hole_type'{start: off_ff, len: n_ff} : rdata_ff;
      adj      = have_last_ff &&
                 ((WIDE_W'(last_ff.start) + WIDE_W'(last_ff.len)) == WIDE_W'(el.start));
   end

   // Status toward the controller
   always_comb begin
      stat            = '0;
      stat.route      = RT_DONE;
      if ((op_ff == OP_ALLOC) && pers_ff && !n_zero) begin
         stat.route = RT_SCAN;
      end else if ((op_ff == OP_RELEASE) && pers_ff && !n_zero && !rel_bad) begin
         stat.route = list_full ? RT_WALK_DRY : RT_WALK_WR;
      end
      stat.scan_last  = cnt_hit || scan_fit;
      stat.scan_shift = !cnt_hit && scan_fit && scan_exact && (idx_inc != hole_cnt_ff);
      stat.shift_last = cnt_hit;
      stat.walk_last  = !pend_ff && cnt_hit;
      stat.walk_over  = (w_ff > CNT_W'(FREE_RANGES));
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Next-state logic
   always_comb begin
      tcap_in = tcap_ff;  pcap_in = pcap_ff;  bound_in = bound_ff;
      op_in = op_ff;  pers_in = pers_ff;  n_in = n_ff;  off_in = off_ff;  frame_in = frame_ff;
      bump_t_in = bump_t_ff;  bump_p_in = bump_p_ff;  cur_frame_in = cur_frame_ff;
      hole_cnt_in = hole_cnt_ff;
      tused_in = tused_ff;  tpeak_in = tpeak_ff;  tret_in = tret_ff;
      pused_in = pused_ff;  ppeak_in = ppeak_ff;  prel_in = prel_ff;  fail_in = fail_ff;
      idx_in = idx_ff;  w_in = w_ff;  pend_in = pend_ff;
      have_last_in = have_last_ff;  last_in = last_ff;
      status_in = status_ff;  goff_in = goff_ff;  gcnt_in = gcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      r_status_in = r_status_ff;  r_goff_in = r_goff_ff;  r_gcnt_in = r_gcnt_ff;
      r_frame_in = r_frame_ff;  r_tused_in = r_tused_ff;  r_tpeak_in = r_tpeak_ff;
      r_tret_in = r_tret_ff;  r_pused_in = r_pused_ff;  r_ppeak_in = r_ppeak_ff;
      r_prel_in = r_prel_ff;  r_fail_in = r_fail_ff;
      we    = 1'b0;
      waddr = idx_ff[IDX_W-1:0];
      wdata = rdata_ff;

      // register writes
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_TCAP:  tcap_in  = csr_wdata;
            CSR_PCAP:  pcap_in  = csr_wdata;
            CSR_BOUND: bound_in = csr_wdata[0];
            default: ;
         endcase
      end

      // take the request word, prime read of entry zero
      if (cmd.start) begin
         op_in    = opcode_type'(req_opcode);
         pers_in  = req_persistent;
         n_in     = req_count;
         off_in   = req_offset;
         frame_in = req_frame_index;
         idx_in   = '0;
      end

      // immediate operations and setup of the list passes
      if (cmd.exec) begin
         idx_in       = '0;
         w_in         = '0;
         pend_in      = 1'b1;
         have_last_in = 1'b0;
         status_in    = RS_OK;
         goff_in      = '0;
         gcnt_in      = '0;
         unique case (op_ff)
            OP_FRAME: begin
               if (frame_ff != cur_frame_ff) begin
                  tret_in      = tret_ff + STAT_W'(bump_t_ff);
                  cur_frame_in = frame_ff;
                  bump_t_in    = '0;
                  tused_in     = '0;
               end else begin
                  tused_in = bump_t_ff;
               end
            end
            OP_ALLOC: begin
               if (n_zero) begin
                  status_in = RS_IGNORED;
               end else if (!pers_ff) begin
                  if (t_fail) begin
                     status_in = RS_NO_SPACE;
                     fail_in   = fail_ff + 1'b1;
                  end else begin
                     goff_in   = bump_t_ff[OFF_W-1:0];
                     gcnt_in   = n_ff;
                     bump_t_in = t_sum[LEN_W-1:0];
                     tused_in  = t_sum[LEN_W-1:0];
                     if (t_sum[LEN_W-1:0] > tpeak_ff) tpeak_in = t_sum[LEN_W-1:0];
                  end
               end
            end
            OP_RELEASE: begin
               if (n_zero || !pers_ff || rel_bad) status_in = RS_IGNORED;
            end
            OP_CLEAR: begin
               bump_t_in    = '0;
               bump_p_in    = '0;
               cur_frame_in = '0;
               hole_cnt_in  = '0;
               tused_in     = '0;
               tpeak_in     = '0;
               tret_in      = '0;
               pused_in     = '0;
               ppeak_in     = '0;
               prel_in      = '0;
               fail_in      = '0;
            end
            default: ;
         endcase
      end

      // first-fit scan, one entry per cycle
      if (cmd.scan) begin
         if (cnt_hit) begin
            if (p_fail) begin
               status_in = RS_NO_SPACE;
               fail_in   = fail_ff + 1'b1;
            end else begin
               goff_in   = bump_p_ff[OFF_W-1:0];
               gcnt_in   = n_ff;
               bump_p_in = p_sum[LEN_W-1:0];
               pused_in  = pused_grow;
               ppeak_in  = ppeak_grow;
            end
         end else if (scan_fit) begin
            goff_in  = rdata_ff.start;
            gcnt_in  = n_ff;
            pused_in = pused_grow;
            ppeak_in = ppeak_grow;
            if (scan_exact) begin
               hole_cnt_in = hole_cnt_ff - 1'b1;
               idx_in      = idx_inc;
            end else begin
               we          = 1'b1;
               waddr       = idx_ff[IDX_W-1:0];
               wdata.start = rdata_ff.start + n_ff[OFF_W-1:0];
               wdata.len   = rdata_ff.len - n_ff;
            end
         end else begin
            idx_in = idx_inc;
         end
      end

      // close the gap left by a used-up hole
      if (cmd.shift) begin
         we     = 1'b1;
         waddr  = idx_dec[IDX_W-1:0];
         wdata  = rdata_ff;
         idx_in = idx_inc;
      end

      // sorted insert with merging; dry pass only counts entries
      if (cmd.walk) begin
         if (!pend_ff && cnt_hit) begin
            if (!cmd.walk_wr) begin
               if (w_ff > CNT_W'(FREE_RANGES)) begin
                  status_in = RS_LIST_FULL;
               end else begin
                  idx_in       = '0;
                  w_in         = '0;
                  pend_in      = 1'b1;
                  have_last_in = 1'b0;
               end
            end else begin
               we          = 1'b1;
               waddr       = w_dec[IDX_W-1:0];
               wdata       = last_ff;
               hole_cnt_in = w_ff;
               pused_in    = pused_rel;
               prel_in     = prel_ff + STAT_W'(n_ff);
            end
         end else begin
            if (take_ins) pend_in = 1'b0;
            else idx_in = idx_inc;
            if (adj) begin
               last_in.len = last_ff.len + el.len;
            end else begin
               if (have_last_ff && cmd.walk_wr) begin
                  we    = 1'b1;
                  waddr = w_dec[IDX_W-1:0];
                  wdata = last_ff;
               end
               last_in      = el;
               have_last_in = 1'b1;
               w_in         = w_ff + 1'b1;
            end
         end
      end

      // response register
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         r_status_in  = status_ff;
         r_goff_in    = goff_ff;
         r_gcnt_in    = gcnt_ff;
         r_frame_in   = cur_frame_ff;
         r_tused_in   = tused_ff;
         r_tpeak_in   = tpeak_ff;
         r_tret_in    = tret_ff;
         r_pused_in   = pused_ff;
         r_ppeak_in   = ppeak_ff;
         r_prel_in    = prel_ff;
         r_fail_in    = fail_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign raddr = idx_in[IDX_W-1:0];

   // Free list storage, registered read
   always_ff @(posedge clock) begin
      if (we) hole_ram[waddr] <= wdata;
      rdata_ff <= hole_ram[raddr];
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tcap_ff      <= TCAP_RESET;
         pcap_ff      <= PCAP_RESET;
         bound_ff     <= 1'b0;
         bump_t_ff    <= '0;
         bump_p_ff    <= '0;
         cur_frame_ff <= '0;
         hole_cnt_ff  <= '0;
         tused_ff     <= '0;
         tpeak_ff     <= '0;
         tret_ff      <= '0;
         pused_ff     <= '0;
         ppeak_ff     <= '0;
         prel_ff      <= '0;
         fail_ff      <= '0;
         idx_ff       <= '0;
         w_ff         <= '0;
         pend_ff      <= 1'b0;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tcap_ff      <= tcap_in;
         pcap_ff      <= pcap_in;
         bound_ff     <= bound_in;
         bump_t_ff    <= bump_t_in;
         bump_p_ff    <= bump_p_in;
         cur_frame_ff <= cur_frame_in;
         hole_cnt_ff  <= hole_cnt_in;
         tused_ff     <= tused_in;
         tpeak_ff     <= tpeak_in;
         tret_ff      <= tret_in;
         pused_ff     <= pused_in;
         ppeak_ff     <= ppeak_in;
         prel_ff      <= prel_in;
         fail_ff      <= fail_in;
         idx_ff       <= idx_in;
         w_ff         <= w_in;
         pend_ff      <= pend_in;
         have_last_ff <= have_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pers_ff    <= pers_in;
      n_ff       <= n_in;
      off_ff     <= off_in;
      frame_ff   <= frame_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
      goff_ff    <= goff_in;
      gcnt_ff    <= gcnt_in;
      r_status_ff <= r_status_in;
      r_goff_ff  <= r_goff_in;
      r_gcnt_ff  <= r_gcnt_in;
      r_frame_ff <= r_frame_in;
      r_tused_ff <= r_tused_in;
      r_tpeak_ff <= r_tpeak_in;
      r_tret_ff  <= r_tret_in;
      r_pused_ff <= r_pused_in;
      r_ppeak_ff <= r_ppeak_in;
      r_prel_ff  <= r_prel_in;
      r_fail_ff  <= r_fail_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = r_status_ff;
   assign rsp_alloc_offset        = r_goff_ff;
   assign rsp_alloc_count         = r_gcnt_ff;
   assign rsp_frame_now           = r_frame_ff;
   assign rsp_transient_used      = r_tused_ff;
   assign rsp_transient_peak      = r_tpeak_ff;
   assign rsp_transient_retired   = r_tret_ff;
   assign rsp_persistent_used     = r_pused_ff;
   assign rsp_persistent_peak     = r_ppeak_ff;
   assign rsp_persistent_released = r_prel_ff;
   assign rsp_failures            = r_fail_ff;

endmodule

// File: hw/rtl/descriptor_range_allocator.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_stall | opcode, persistent, count, offset, frame_index
// rsp     | out       | rsp_valid/rsp_stall | status, grant and statistics
// csr     | in        | csr_write           | csr_index, csr_wdata
//
// One word at a time. Frame, clear, transient and ignored words go from execute
// straight to finish. A persistent allocate also scans the free list entry by entry,
// then shifts the later entries down when a hole is used up; a release walks every
// entry, and when the list is full a counting pass runs before the writing pass.
// The free-list memory walk sets the worst case.
// Reset is synchronous; the free-list memory is not cleared, only its fill count.
// The response register lets a new word be taken while a result waits on rsp_stall.
module descriptor_range_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic                            req_persistent,
   input  logic [dra_pkg::LEN_W-1:0]       req_count,
   input  logic [dra_pkg::OFF_W-1:0]       req_offset,
   input  logic [dra_pkg::FRAME_W-1:0]     req_frame_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [dra_pkg::OFF_W-1:0]       rsp_alloc_offset,
   output logic [dra_pkg::LEN_W-1:0]       rsp_alloc_count,
   output logic [dra_pkg::FRAME_W-1:0]     rsp_frame_now,
   output logic [dra_pkg::LEN_W-1:0]       rsp_transient_used,
   output logic [dra_pkg::LEN_W-1:0]       rsp_transient_peak,
   output logic [dra_pkg::STAT_W-1:0]      rsp_transient_retired,
   output logic [dra_pkg::LEN_W-1:0]       rsp_persistent_used,
   output logic [dra_pkg::LEN_W-1:0]       rsp_persistent_peak,
   output logic [dra_pkg::STAT_W-1:0]      rsp_persistent_released,
   output logic [dra_pkg::STAT_W-1:0]      rsp_failures,
   input  logic                            csr_write,
   input  logic [dra_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dra_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dra_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dra_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_opcode              (req_opcode),
      .req_persistent          (req_persistent),
      .req_count               (req_count),
      .req_offset              (req_offset),
      .req_frame_index         (req_frame_index),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .cmd                     (cmd),
      .stat                    (stat),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_alloc_offset        (rsp_alloc_offset),
      .rsp_alloc_count         (rsp_alloc_count),
      .rsp_frame_now           (rsp_frame_now),
      .rsp_transient_used      (rsp_transient_used),
      .rsp_transient_peak      (rsp_transient_peak),
      .rsp_transient_retired   (rsp_transient_retired),
      .rsp_persistent_used     (rsp_persistent_used),
      .rsp_persistent_peak     (rsp_persistent_peak),
      .rsp_persistent_released (rsp_persistent_released),
      .rsp_failures            (rsp_failures)
   );

   // at most one step command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.exec, cmd.scan, cmd.shift, cmd.walk, cmd.finish}))
      else $error("controller issued overlapping commands");

   // a finished word always shows up on the response port
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished word not presented");

   // after taking a word the block is busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("request taken while busy");

endmodule
